// ===== sv/csrsg_pkg.sv =====
`default_nettype none

package csrsg_pkg;

    localparam int COORD_BITS    = 16;
    localparam int DISTANCE_BITS = 8;

    localparam int MAG_BITS   = (COORD_BITS > DISTANCE_BITS) ? COORD_BITS : DISTANCE_BITS;
    localparam int RAD_BITS   = MAG_BITS + 2;
    localparam int ARITH_BITS = MAG_BITS + 4;

    localparam int S_DATA_BITS = ((4 * COORD_BITS + DISTANCE_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [DISTANCE_BITS-1:0]     dist_t;
    typedef logic [RAD_BITS-1:0]          rad_t;
    typedef logic signed [ARITH_BITS-1:0] arith_t;
    typedef logic [2:0]                   phase_t;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    // Candidate k of an offset row: bit k of each mask describes its shape.
    localparam logic [7:0] VAR_ON_X = 8'b0101_0101;
    localparam logic [7:0] VAR_NEG  = 8'b1100_0011;
    localparam logic [7:0] FIX_NEG  = 8'b1001_1001;

    localparam phase_t PHASE_LAST = 3'd7;

    typedef enum logic [1:0] {
        STAGE_FINISHED,
        STAGE_RING,
        STAGE_CENTER
    } stage_t;

    typedef struct packed {
        logic load;
        logic step;
        logic emit_ring;
        logic emit_center;
        logic emit_none;
        logic finish;
        logic lanes;
        logic pick;
    } ctrl_cmd_t;

    typedef struct packed {
        stage_t stage;
        logic   cand_ok;
        logic   phase_last;
        logic   center_ok;
        logic   out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/csrsg_datapath.sv =====
`default_nettype none

module csrsg_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  csrsg_pkg::ctrl_cmd_t  cmd,
    input  csrsg_pkg::coord_t     scan_x,
    input  csrsg_pkg::coord_t     scan_y,
    input  csrsg_pkg::coord_t     window_x,
    input  csrsg_pkg::coord_t     window_y,
    input  csrsg_pkg::dist_t      distance,
    output csrsg_pkg::dp_stat_t   stat,
    output csrsg_pkg::coord_t     tile_x,
    output csrsg_pkg::coord_t     tile_y,
    output logic                  found,
    output logic                  out_valid,
    input  logic                  out_ready
);
    import csrsg_pkg::*;

    function automatic arith_t abs_a(arith_t v);
        return (v < 0) ? -v : v;
    endfunction

    coord_t center_col_reg, center_col_next;
    coord_t center_row_reg, center_row_next;
    arith_t ax_reg, ax_next;
    arith_t ay_reg, ay_next;
    dist_t  dist_reg, dist_next;
    rad_t   radius_reg, radius_next;
    rad_t   offset_reg, offset_next;
    rad_t   floor_reg, floor_next;
    phase_t phase_reg, phase_next;
    stage_t stage_reg, stage_next;

    logic   out_valid_reg, out_valid_next;
    coord_t tile_x_reg, tile_x_next;
    coord_t tile_y_reg, tile_y_next;
    logic   found_reg, found_next;

    logic [7:0] lane_v_reg;
    arith_t     lane_c_reg [8];
    logic [7:0] lane_v_next;
    arith_t     lane_c_next [8];

    arith_t r_a, i_a, d_a, px, py, sum_x, sum_y;
    logic   out_free, cand_ok, center_ok;
    logic   best_v;
    arith_t best_c;

    assign r_a = arith_t'(radius_reg);
    assign i_a = arith_t'(offset_reg);
    assign d_a = arith_t'(dist_reg);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        arith_t v, f;
        logic   applicable;
        v = VAR_NEG[phase_reg] ? -i_a : i_a;
        f = FIX_NEG[phase_reg] ? -r_a : r_a;
        px = VAR_ON_X[phase_reg] ? v : f;
        py = VAR_ON_X[phase_reg] ? f : v;
        applicable = phase_reg[2] || (i_a > 0 && i_a < r_a);
        cand_ok = applicable && (abs_a(px - ax_reg) <= d_a) && (abs_a(py - ay_reg) <= d_a);
        center_ok = (abs_a(ax_reg) <= d_a) && (abs_a(ay_reg) <= d_a);
        sum_x = arith_t'(center_col_reg) + px;
        sum_y = arith_t'(center_row_reg) + py;
    end

    assign stat.stage      = stage_reg;
    assign stat.cand_ok    = cand_ok;
    assign stat.phase_last = (phase_reg == PHASE_LAST);
    assign stat.center_ok  = center_ok;
    assign stat.out_free   = out_free;

    // Each lane finds the largest offset below the current one at which its
    // candidate falls inside the window.
    always_comb
    begin
        arith_t a, b, lo, hi, c;
        for (int k = 0; k < 8; k++)
        begin
            a = VAR_ON_X[k] ? ax_reg : ay_reg;
            b = VAR_ON_X[k] ? ay_reg : ax_reg;
            lo = VAR_NEG[k] ? (-a - d_a) : (a - d_a);
            hi = VAR_NEG[k] ? (-a + d_a) : (a + d_a);
            if (k < 4)
            begin
                if (lo < 1)
                    lo = 1;
                if (hi > r_a - 1)
                    hi = r_a - 1;
            end
            else
            begin
                if (lo < 0)
                    lo = 0;
                if (hi > r_a)
                    hi = r_a;
            end
            c = (hi < i_a - 1) ? hi : (i_a - 1);
            lane_c_next[k] = c;
            lane_v_next[k] = (abs_a((FIX_NEG[k] ? -r_a : r_a) - b) <= d_a) && (c >= lo);
        end
    end

    always_comb
    begin
        best_v = 1'b0;
        best_c = '0;
        for (int k = 0; k < 8; k++)
        begin
            if (lane_v_reg[k] && (!best_v || lane_c_reg[k] > best_c))
            begin
                best_v = 1'b1;
                best_c = lane_c_reg[k];
            end
        end
    end

    always_comb
    begin
        arith_t ax_w, ay_w, rx, ry, mx, my, mf;
        center_col_next = center_col_reg;
        center_row_next = center_row_reg;
        ax_next         = ax_reg;
        ay_next         = ay_reg;
        dist_next       = dist_reg;
        radius_next     = radius_reg;
        offset_next     = offset_reg;
        floor_next      = floor_reg;
        phase_next      = phase_reg;
        stage_next      = stage_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        tile_x_next     = tile_x_reg;
        tile_y_next     = tile_y_reg;
        found_next      = found_reg;

        ax_w = arith_t'(window_x) - arith_t'(scan_x);
        ay_w = arith_t'(window_y) - arith_t'(scan_y);
        rx = abs_a(ax_w) + arith_t'(distance);
        ry = abs_a(ay_w) + arith_t'(distance);
        mx = abs_a(ax_w) - arith_t'(distance);
        my = abs_a(ay_w) - arith_t'(distance);
        mf = (mx > my) ? mx : my;
        if (mf < 1)
            mf = 1;

        if (cmd.load)
        begin
            center_col_next = scan_x;
            center_row_next = scan_y;
            ax_next         = ax_w;
            ay_next         = ay_w;
            dist_next       = distance;
            radius_next     = (rx > ry) ? rad_t'(rx) : rad_t'(ry);
            offset_next     = (rx > ry) ? rad_t'(rx) : rad_t'(ry);
            floor_next      = rad_t'(mf);
            phase_next      = '0;
            stage_next      = (rx >= 1 || ry >= 1) ? STAGE_RING : STAGE_CENTER;
        end

        if (cmd.step)
            phase_next = phase_reg + 3'd1;

        if (cmd.emit_ring)
        begin
            out_valid_next = 1'b1;
            tile_x_next    = sum_x[COORD_BITS-1:0];
            tile_y_next    = sum_y[COORD_BITS-1:0];
            found_next     = 1'b1;
            if (phase_reg != PHASE_LAST)
                phase_next = phase_reg + 3'd1;
            else
            begin
                phase_next = '0;
                if (offset_reg != '0)
                    offset_next = offset_reg - rad_t'(1);
                else if (radius_reg > rad_t'(1))
                begin
                    radius_next = radius_reg - rad_t'(1);
                    offset_next = radius_reg - rad_t'(1);
                end
                else
                begin
                    radius_next = '0;
                    offset_next = '0;
                    stage_next  = STAGE_CENTER;
                end
            end
        end

        if (cmd.emit_center)
        begin
            out_valid_next = 1'b1;
            tile_x_next    = center_col_reg;
            tile_y_next    = center_row_reg;
            found_next     = 1'b1;
            stage_next     = STAGE_FINISHED;
        end

        if (cmd.emit_none)
        begin
            out_valid_next = 1'b1;
            tile_x_next    = '0;
            tile_y_next    = '0;
            found_next     = 1'b0;
            stage_next     = STAGE_FINISHED;
        end

        if (cmd.finish)
            stage_next = STAGE_FINISHED;

        // Rings below the floor never reach the window, so they are passed over.
        if (cmd.pick)
        begin
            phase_next = '0;
            if (best_v)
                offset_next = rad_t'(best_c);
            else if (radius_reg > floor_reg)
            begin
                radius_next = radius_reg - rad_t'(1);
                offset_next = radius_reg - rad_t'(1);
            end
            else
            begin
                radius_next = '0;
                offset_next = '0;
                stage_next  = STAGE_CENTER;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_col_reg <= '0;
            center_row_reg <= '0;
            ax_reg         <= '0;
            ay_reg         <= '0;
            dist_reg       <= '0;
            radius_reg     <= '0;
            offset_reg     <= '0;
            floor_reg      <= '0;
            phase_reg      <= '0;
            stage_reg      <= STAGE_FINISHED;
            out_valid_reg  <= 1'b0;
            tile_x_reg     <= '0;
            tile_y_reg     <= '0;
            found_reg      <= 1'b0;
        end
        else
        begin
            center_col_reg <= center_col_next;
            center_row_reg <= center_row_next;
            ax_reg         <= ax_next;
            ay_reg         <= ay_next;
            dist_reg       <= dist_next;
            radius_reg     <= radius_next;
            offset_reg     <= offset_next;
            floor_reg      <= floor_next;
            phase_reg      <= phase_next;
            stage_reg      <= stage_next;
            out_valid_reg  <= out_valid_next;
            tile_x_reg     <= tile_x_next;
            tile_y_reg     <= tile_y_next;
            found_reg      <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lanes)
        begin
            lane_v_reg <= lane_v_next;
            for (int k = 0; k < 8; k++)
                lane_c_reg[k] <= lane_c_next[k];
        end
    end

    assign tile_x    = tile_x_reg;
    assign tile_y    = tile_y_reg;
    assign found     = found_reg;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== sv/csrsg_ctrl.sv =====
`default_nettype none

module csrsg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_cmd,
    output logic                 in_ready,
    input  csrsg_pkg::dp_stat_t  stat,
    output csrsg_pkg::ctrl_cmd_t cmd
);
    import csrsg_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_LANES,
        ST_PICK
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_cmd == CMD_START)
                        cmd.load = 1'b1;
                    else
                        state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                case (stat.stage)
                    STAGE_RING:
                    begin
                        if (stat.cand_ok)
                        begin
                            if (stat.out_free)
                            begin
                                cmd.emit_ring = 1'b1;
                                state_next    = ST_IDLE;
                            end
                        end
                        else if (stat.phase_last)
                            state_next = ST_LANES;
                        else
                            cmd.step = 1'b1;
                    end
                    STAGE_CENTER:
                    begin
                        if (!stat.center_ok)
                            cmd.finish = 1'b1;
                        else if (stat.out_free)
                        begin
                            cmd.emit_center = 1'b1;
                            state_next      = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit_none = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_LANES:
            begin
                cmd.lanes  = 1'b1;
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = ST_SEARCH;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign in_ready = ready_reg;

endmodule

`default_nettype wire

// ===== sv/clipped_square_ring_scan_generator_unit.sv =====
`default_nettype none

// Walks square rings around a scan center from the outer radius inward and
// returns, one per next transaction, the tiles that lie inside the clip window;
// the scan center comes last, and once nothing is left a next transaction
// answers with found clear. A start transaction gives no result. A next
// transaction is accepted, then tests the candidates of an offset row in turn
// until one is taken; when the last candidate of a row is rejected, the
// eight-lane offset search jumps to the next offset in the ring that can give
// a tile, or else to the next ring inward. Results wait in an output register,
// so a new transaction is taken while a result is still pending.
module clipped_square_ring_scan_generator_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // scan_x, scan_y, window_x, window_y, distance
    input  logic [csrsg_pkg::S_DATA_BITS-1:0] s_axis_tdata,
    // cmd
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tile_x, tile_y
    output logic [csrsg_pkg::M_DATA_BITS-1:0] m_axis_tdata,
    // found
    output logic                              m_axis_tuser
);
    import csrsg_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;
    coord_t    tile_x, tile_y;
    coord_t    scan_x, scan_y, window_x, window_y;
    dist_t     distance;

    assign scan_x   = s_axis_tdata[COORD_BITS-1:0];
    assign scan_y   = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign window_x = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign window_y = s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];
    assign distance = s_axis_tdata[4*COORD_BITS+DISTANCE_BITS-1:4*COORD_BITS];

    csrsg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_cmd   (s_axis_tuser),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    csrsg_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .scan_x    (scan_x),
        .scan_y    (scan_y),
        .window_x  (window_x),
        .window_y  (window_y),
        .distance  (distance),
        .stat      (stat),
        .tile_x    (tile_x),
        .tile_y    (tile_y),
        .found     (m_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tdata = M_DATA_BITS'({tile_y, tile_x});

endmodule

`default_nettype wire
